// ----- hdl/chs_pkg.sv -----
// ----------------------------------------------------------------------------
// chs_pkg
// Shared constants, codes and controller/datapath types of the hash set.
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

  localparam int MAX_BUCKETS_DEF = 64;
  localparam int CHAIN_DEPTH_DEF = 8;

  localparam int KEY_W    = 32;
  localparam int OP_W     = 2;
  localparam int CFG_W    = 7;
  localparam int CFG_RST  = 64;
  localparam int STAT_W   = 2;
  localparam int OUT_IW   = 6;
  localparam int OUT_LW   = 4;

  // remainder unit: DIV_BITS dividend bits per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = KEY_W / DIV_BITS;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_LEN, S_SCAN_RD, S_SCAN_CMP,
    S_EXEC, S_SHIFT_RD, S_SHIFT_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic div_step;
    logic len_rd;
    logic scan_rd;
    logic scan_cmp;
    logic exec;
    logic shift_rd;
    logic shift_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic scan_end;
    logic hit;
    logic is_rem;
    logic found;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/chs_ctrl.sv -----
// ----------------------------------------------------------------------------
// chs_ctrl
// Sequencer: clearing pass, remainder, chain scan, update and compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_ctrl
  import chs_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_LEN;
      end
      S_LEN: begin
        cmd.len_rd = 1'b1;
        state_nxt  = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (sts.scan_end) state_nxt = S_EXEC;
        else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_nxt    = sts.hit ? S_EXEC : S_SCAN_RD;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (sts.is_rem && sts.found) ? S_SHIFT_RD : S_DONE;
      end
      S_SHIFT_RD: begin
        if (sts.scan_end) state_nxt = S_DONE;
        else begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/chs_datapath.sv -----
// ----------------------------------------------------------------------------
// chs_datapath
// Remainder unit, length and key memories, scan/shift pointer, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_datapath
  import chs_pkg::*;
#(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int CHAIN_DEPTH = CHAIN_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_wr_en,
  input  wire  [CFG_W-1:0]  cfg_wr_data,
  input  wire  [OP_W-1:0]   in_op,
  input  wire  [KEY_W-1:0]  in_key,
  input  wire               out_tready,
  output logic              out_tvalid,
  output logic [STAT_W-1:0] out_status,
  output logic              out_found,
  output logic [OUT_IW-1:0] out_index,
  output logic [OUT_LW-1:0] out_length,
  input  cmd_t              cmd,
  output sts_t              sts
);

  localparam int BW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int LW   = $clog2(CHAIN_DEPTH + 1);
  localparam int MODW = ($clog2(MAX_BUCKETS + 1) > CFG_W) ? $clog2(MAX_BUCKETS + 1) : CFG_W;
  localparam int KDEP = MAX_BUCKETS * CHAIN_DEPTH;
  localparam int AW   = (KDEP > 1) ? $clog2(KDEP) : 1;

  function automatic logic [AW-1:0] kaddr(input logic [BW-1:0] b, input logic [LW-1:0] s);
    kaddr = AW'(b) * AW'(CHAIN_DEPTH) + AW'(s);
  endfunction

  logic [CFG_W-1:0]  bucket_count_r;
  logic [OP_W-1:0]   op_r;
  logic [KEY_W-1:0]  key_r, dvd_r;
  logic [MODW-1:0]   mod_r, rem_r, mod_nxt, rem_nxt;
  logic [DIV_CW-1:0] div_cnt_r;
  logic [BW-1:0]     clr_cnt_r, bkt;
  logic [LW-1:0]     len_q_r, idx_r, len_new;
  logic [KEY_W-1:0]  key_q_r;
  logic              found_r, out_valid_r;
  logic [STAT_W-1:0] stat_r;
  logic              full;

  logic [LW-1:0]    len_mem [MAX_BUCKETS];
  logic [KEY_W-1:0] key_mem [KDEP];

  assign bkt  = rem_r[BW-1:0];
  assign full = (len_q_r >= LW'(CHAIN_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) bucket_count_r <= CFG_W'(CFG_RST);
    else if (cfg_wr_en) bucket_count_r <= cfg_wr_data;
  end

  // clamp the modulus to 1..MAX_BUCKETS
  always_comb begin
    if (bucket_count_r == '0) mod_nxt = MODW'(1);
    else if (MODW'(bucket_count_r) > MODW'(MAX_BUCKETS)) mod_nxt = MODW'(MAX_BUCKETS);
    else mod_nxt = MODW'(bucket_count_r);
  end

  // DIV_BITS restoring steps per cycle; remainder stays below the modulus
  always_comb begin
    logic [MODW:0] r;
    r = {1'b0, rem_r};
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[MODW-1:0], dvd_r[KEY_W-1-i]};
      if (r >= {1'b0, mod_r}) r = r - {1'b0, mod_r};
    end
    rem_nxt = r[MODW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + BW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      key_r     <= in_key;
      dvd_r     <= in_key;
      mod_r     <= mod_nxt;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      dvd_r     <= dvd_r << DIV_BITS;
      div_cnt_r <= div_cnt_r + DIV_CW'(1);
    end
    if (cmd.len_rd) begin
      len_q_r <= len_mem[bkt];
      idx_r   <= '0;
      found_r <= 1'b0;
    end
    if (cmd.scan_rd) key_q_r <= key_mem[kaddr(bkt, idx_r)];
    if (cmd.shift_rd) key_q_r <= key_mem[kaddr(bkt, idx_r + LW'(1))];
    if (cmd.scan_cmp) begin
      if (key_q_r == key_r) found_r <= 1'b1;
      else                  idx_r   <= idx_r + LW'(1);
    end
    if (cmd.shift_wr) idx_r <= idx_r + LW'(1);
    if (cmd.exec) begin
      if (op_r == OP_INSERT) stat_r <= full ? STAT_FULL : STAT_OK;
      else                   stat_r <= found_r ? STAT_OK : STAT_NOT_FOUND;
      len_q_r <= len_new;
    end
    if (cmd.out_load) begin
      out_status <= stat_r;
      out_found  <= found_r;
      out_index  <= OUT_IW'(bkt);
      out_length <= OUT_LW'(len_q_r);
    end
  end

  // length after the operation
  always_comb begin
    len_new = len_q_r;
    if (op_r == OP_INSERT && !full)        len_new = len_q_r + LW'(1);
    else if (op_r == OP_REMOVE && found_r) len_new = len_q_r - LW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr)    len_mem[clr_cnt_r] <= '0;
    else if (cmd.exec) len_mem[bkt]       <= len_new;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && op_r == OP_INSERT && !full) key_mem[kaddr(bkt, len_q_r)] <= key_r;
    else if (cmd.shift_wr)                      key_mem[kaddr(bkt, idx_r)]   <= key_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    sts          = '0;
    sts.clr_last = (clr_cnt_r == BW'(MAX_BUCKETS - 1));
    sts.div_last = (div_cnt_r == DIV_CW'(DIV_STEPS - 1));
    sts.scan_end = (idx_r >= len_q_r);
    sts.hit      = (key_q_r == key_r);
    sts.is_rem   = (op_r == OP_REMOVE);
    sts.found    = found_r;
    sts.out_busy = out_valid_r && !out_tready;
  end

endmodule

`default_nettype wire

// ----- hdl/chained_hash_set.sv -----
// ----------------------------------------------------------------------------
// chained_hash_set
// Bounded hash set of 32-bit keys, separate chaining, key mod bucket count.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. After reset a clearing pass zeroes the
// chain lengths, one bucket a cycle, during which no beat is taken
// (configuration writes still land). An operation then accepts the beat,
// forms the remainder (4 key bits a cycle), reads the chain length, scans
// the chain with a read and a compare per entry (single-port key memory
// with registered read) until a hit or the end of the chain, updates the
// length and key memories, on a remove that hit moves each later entry
// down by one (a read and a write per entry) up to the end of the chain,
// and loads the result. Loading the result waits while the output register
// still holds an unaccepted beat.
// A finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_set
  import chs_pkg::*;
#(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int CHAIN_DEPTH = CHAIN_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // configuration: bucket_count
  input  wire         cfg_wr_en,
  input  wire  [6:0]  cfg_wr_data,
  // request beat
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] key_value
  input  wire  [1:0]  in_tuser,   // [1:0] opcode
  // result beat
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [2] found, [8:3] bucket_index,
                                  // [12:9] bucket_length, [15:13] zero
);

  cmd_t cmd;
  sts_t sts;

  logic [STAT_W-1:0] status;
  logic              found;
  logic [OUT_IW-1:0] index;
  logic [OUT_LW-1:0] length;

  chs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  chs_datapath #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_op       (in_tuser),
    .in_key      (in_tdata),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_status  (status),
    .out_found   (found),
    .out_index   (index),
    .out_length  (length),
    .cmd         (cmd),
    .sts         (sts)
  );

  assign out_tdata = {3'b000, length, index, found, status};

endmodule

`default_nettype wire

// ----- dv/chained_hash_set_tb.sv -----
// ----------------------------------------------------------------------------
// chained_hash_set_tb
// Self-checking bench for the chained hash set: a behavioural copy of the set
// predicts each result beat, and a scoreboard compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_set_tb;
  import chs_pkg::*;

  localparam int NBKT  = 64;
  localparam int DEPTH = 8;
  localparam int WDOG  = 20000;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [5:0] bkt;
    logic [3:0] len;
  } hs_result_t;

  // behavioural hash set plus queue of pending result beats
  class hash_set_sb;
    logic [31:0] keys [NBKT][DEPTH];
    int unsigned lens [NBKT];
    logic [6:0]  nbuckets;
    hs_result_t  pending [$];
    int          errors;

    function void clear();
      foreach (lens[i]) lens[i] = 0;
      nbuckets = 7'(CFG_RST);
      pending.delete();
      errors = 0;
    endfunction

    function void set_count(logic [6:0] v);
      nbuckets = v;
    endfunction

    // note an accepted request: apply it and queue the result
    function void note_request(logic [1:0] op, logic [31:0] key);
      int unsigned m, b, n, i;
      int slot;
      hs_result_t r;
      m = nbuckets;
      if (m == 0) m = 1;
      if (m > NBKT) m = NBKT;
      b = key % m;
      n = lens[b];
      slot = -1;
      for (i = 0; i < n; i++)
        if (slot < 0 && keys[b][i] == key) slot = i;
      if (op == OP_INSERT) begin
        if (n >= DEPTH) r.status = STAT_FULL;
        else begin
          keys[b][n] = key;
          lens[b] = n + 1;
          r.status = STAT_OK;
        end
      end else if (op == OP_REMOVE) begin
        if (slot < 0) r.status = STAT_NOT_FOUND;
        else begin
          for (i = slot; i + 1 < n; i++) keys[b][i] = keys[b][i+1];
          lens[b] = n - 1;
          r.status = STAT_OK;
        end
      end else begin
        r.status = (slot < 0) ? STAT_NOT_FOUND : STAT_OK;
      end
      r.found = (slot >= 0);
      r.bkt   = b[5:0];
      r.len   = lens[b][3:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [15:0] d);
      hs_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[1:0] !== e.status) begin
        $display("%0t: status exp %0d got %0d", $realtime, e.status, d[1:0]);
        errors++;
      end
      if (d[2] !== e.found) begin
        $display("%0t: found exp %0d got %0d", $realtime, e.found, d[2]);
        errors++;
      end
      if (d[8:3] !== e.bkt) begin
        $display("%0t: bucket exp %0d got %0d", $realtime, e.bkt, d[8:3]);
        errors++;
      end
      if (d[12:9] !== e.len) begin
        $display("%0t: length exp %0d got %0d", $realtime, e.len, d[12:9]);
        errors++;
      end
      if (d[15:13] !== 3'b000) begin
        $display("%0t: pad exp 0 got %0d", $realtime, d[15:13]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  always #6 clk = ~clk;

  chained_hash_set u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  hash_set_sb sb = new();

  // idle percentages for each side; phase sets them
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned stall_cnt = 0;
  logic        timed_out = 1'b0;

  // receiver: random stalls, check each result beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WDOG) timed_out <= 1'b1;
  end

  // one request beat, with a random gap before it; valid drops only in a gap
  task automatic send_req(logic [1:0] op, logic [31:0] key);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, key);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_count(logic [6:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_count(v);
  endtask

  // mostly keys from a small pool so chains fill, hit and get removed
  task automatic random_ops(int cnt, int pool);
    logic [31:0] k;
    logic [1:0]  op;
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(9) < 8) k = $urandom_range(pool - 1) * 7 + 3;
      else k = $urandom;
      op = $urandom_range(9) < 4 ? OP_INSERT : 2'($urandom_range(3));
      send_req(op, k);
    end
  endtask

  initial begin
    sb.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme keys, every opcode, full chain, removal compaction
    send_req(OP_INSERT, 32'hFFFF_FFFF);
    send_req(OP_INSERT, 32'h0);
    send_req(2'd2, 32'hFFFF_FFFF);
    send_req(2'd3, 32'h0000_0040);
    send_req(OP_REMOVE, 32'h1234_5678);
    for (int i = 0; i < 9; i++) send_req(OP_INSERT, 32'd5 + 64 * (i % 3));
    send_req(OP_REMOVE, 32'd69);
    send_req(2'd2, 32'd69);
    send_req(OP_INSERT, 32'd5);
    send_req(OP_INSERT, 32'd5);
    send_req(OP_REMOVE, 32'd5);
    send_req(2'd2, 32'd133);
    drain();

    // zero count acts as one bucket, so every key lands in the same chain
    write_count(7'd0);
    for (int i = 0; i < 10; i++) send_req(2'($urandom_range(3)), $urandom);
    drain();
    write_count(7'd127);
    send_req(2'd2, 32'hFFFF_FFFF);
    send_req(OP_INSERT, 32'h8000_003F);
    drain();

    // random phases over counts and idling styles
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 61; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 61; end
        default: begin send_idle = 7; recv_idle = 7; end
      endcase
      case (ph % 6)
        0: write_count(7'd1);
        1: write_count(7'd64);
        2: write_count(7'd65);
        3: write_count(7'($urandom_range(2, 63)));
        4: write_count(7'd3);
        default: write_count(7'($urandom_range(127)));
      endcase
      random_ops(145, (ph % 2) ? 40 : 200);
      drain();
    end

    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
